>>> rtl/lfcf_pkg.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter package
// Shared sizes, register codes, command and configuration structs, saturation.
// ----------------------------------------------------------------------------
package lfcf_pkg;

  localparam int DELAY_DEPTH   = 2048;
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 16;

  localparam int ADDR_BITS     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int LEN_BITS      = $clog2(DELAY_DEPTH + 1);
  localparam int DAMP_BITS     = COEF_BITS + 1;
  localparam int MULB_BITS     = COEF_BITS + 2;
  localparam int PROD_BITS     = SAMPLE_BITS + MULB_BITS;
  localparam int ACC_BITS      = PROD_BITS + 1;
  localparam int WIDE_BITS     = ACC_BITS - COEF_BITS;
  localparam int LEN_RESET_RAW = 1116;
  localparam int LEN_RESET     = (LEN_RESET_RAW > DELAY_DEPTH) ? DELAY_DEPTH : LEN_RESET_RAW;
  localparam int DATA_BITS     = 32;
  localparam int CFG_ADDR_BITS = 4;

  localparam logic [DAMP_BITS-1:0] UNITY  = {1'b1, {COEF_BITS{1'b0}}};
  localparam logic [COEF_BITS-1:0] FB_MAX = {COEF_BITS{1'b1}};
  localparam logic [ACC_BITS-1:0]  HALF   = ACC_BITS'(1) << (COEF_BITS - 1);

  typedef enum logic [1:0] {
    REG_DAMP         = 2'd0,
    REG_FEEDBACK     = 2'd1,
    REG_DELAY_LENGTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_DRY  = 2'd0,
    MUL_DAMP = 2'd1,
    MUL_FB   = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [DAMP_BITS-1:0] damp;
    logic [COEF_BITS-1:0] feedback;
    logic [LEN_BITS-1:0]  delay_length;
    logic                 clear;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     state_load;
    logic     write_back;
  } cmd_t;

  // Clamp a widened value to the signed sample range.
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [WIDE_BITS-1:0] v);
    logic [WIDE_BITS-SAMPLE_BITS:0] upper;
    upper = v[WIDE_BITS-1:SAMPLE_BITS-1];
    if ((&upper) || !(|upper)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/lfcf_stream_if.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter stream interfaces
// Valid/ready channels for input and result samples.
// ----------------------------------------------------------------------------
interface lfcf_in_if;
  import lfcf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface lfcf_out_if;
  import lfcf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/lfcf_ram.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lfcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lfcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter configuration registers
// APB-style register file for damp, feedback and delay length.
// ----------------------------------------------------------------------------
module lfcf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfcf_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [lfcf_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lfcf_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  output lfcf_pkg::cfg_t                   cfg
);
  import lfcf_pkg::*;

  logic [DAMP_BITS-1:0] damp_r, damp_nxt;
  logic [COEF_BITS-1:0] feedback_r, feedback_nxt;
  logic [LEN_BITS-1:0]  length_r, length_nxt;
  logic                 wr_en;
  logic                 clear;
  reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_comb begin
    damp_nxt     = damp_r;
    feedback_nxt = feedback_r;
    length_nxt   = length_r;
    clear        = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_DAMP: begin
          damp_nxt = (pwdata > DATA_BITS'(UNITY)) ? UNITY : pwdata[DAMP_BITS-1:0];
        end
        REG_FEEDBACK: begin
          feedback_nxt = (pwdata > DATA_BITS'(FB_MAX)) ? FB_MAX : pwdata[COEF_BITS-1:0];
        end
        REG_DELAY_LENGTH: begin
          clear = 1'b1;
          if (pwdata == '0) begin
            length_nxt = LEN_BITS'(1);
          end else if (pwdata > DATA_BITS'(DELAY_DEPTH)) begin
            length_nxt = LEN_BITS'(DELAY_DEPTH);
          end else begin
            length_nxt = pwdata[LEN_BITS-1:0];
          end
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r     <= '0;
      feedback_r <= '0;
      length_r   <= LEN_BITS'(LEN_RESET);
    end else begin
      damp_r     <= damp_nxt;
      feedback_r <= feedback_nxt;
      length_r   <= length_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_DAMP:         prdata = DATA_BITS'(damp_r);
      REG_FEEDBACK:     prdata = DATA_BITS'(feedback_r);
      REG_DELAY_LENGTH: prdata = DATA_BITS'(length_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.damp         = damp_r;
  assign cfg.feedback     = feedback_r;
  assign cfg.delay_length = length_r;
  assign cfg.clear        = clear;

endmodule

>>> rtl/lfcf_ctrl.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter controller
// Sequences the shared multiplier, the line access and the result handshake.
// ----------------------------------------------------------------------------
module lfcf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lfcf_pkg::cmd_t cmd
);
  import lfcf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DRY  = 6'b000010,
    ST_DAMP = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_FB   = 6'b010000,
    ST_WR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_DRY;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DRY;
        end
      end
      ST_DRY: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_DRY;
        state_nxt    = ST_DAMP;
      end
      ST_DAMP: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_DAMP;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.state_load = 1'b1;
        state_nxt      = ST_FB;
      end
      ST_FB: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_FB;
        state_nxt    = ST_WR;
      end
      ST_WR: begin
        // The line is written only once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.write_back = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.write_back) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/lfcf_dp.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter datapath
// Delay line, write position, shared multiplier, lowpass state and rounding.
// ----------------------------------------------------------------------------
module lfcf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lfcf_pkg::cmd_t                     cmd,
  input  lfcf_pkg::cfg_t                     cfg,
  input  logic signed [lfcf_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic signed [lfcf_pkg::SAMPLE_BITS-1:0] sample_out
);
  import lfcf_pkg::*;

  logic [ADDR_BITS-1:0]          pos_r;
  logic                          wrapped_r;
  logic [SAMPLE_BITS-1:0]        x_r;
  logic [SAMPLE_BITS-1:0]        delayed_r;
  logic [SAMPLE_BITS-1:0]        state_r;
  logic [SAMPLE_BITS-1:0]        out_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [PROD_BITS-1:0]   acc_r;

  logic [SAMPLE_BITS-1:0]        rdata;
  logic [SAMPLE_BITS-1:0]        delayed;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [MULB_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]   mul_p;
  logic [ACC_BITS-1:0]           upd_sum;
  logic [ACC_BITS-1:0]           fb_sum;
  logic [WIDE_BITS-1:0]          wr_sum;
  logic [SAMPLE_BITS-1:0]        wr_data;
  logic [LEN_BITS:0]             pos_inc;
  logic                          pos_wrap;

  // Until the position has wrapped once since the last clear, the entry at the
  // position has not been written and reads as zero.
  assign delayed = wrapped_r ? rdata : '0;

  always_comb begin
    case (cmd.mul_sel)
      MUL_DRY: begin
        mul_a = $signed(delayed);
        mul_b = $signed({1'b0, UNITY - cfg.damp});
      end
      MUL_DAMP: begin
        mul_a = $signed(state_r);
        mul_b = $signed({1'b0, cfg.damp});
      end
      MUL_FB: begin
        mul_a = $signed(state_r);
        mul_b = $signed({2'b00, cfg.feedback});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Round to nearest by adding one half, then taking the floor of the shift.
  assign upd_sum = {acc_r[PROD_BITS-1], acc_r} + {prod_r[PROD_BITS-1], prod_r} + HALF;
  assign fb_sum  = {prod_r[PROD_BITS-1], prod_r} + HALF;
  assign wr_sum  = fb_sum[ACC_BITS-1:COEF_BITS]
                 + {{(WIDE_BITS-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
  assign wr_data = sat_sample(wr_sum);

  assign pos_inc  = (LEN_BITS+1)'(pos_r) + (LEN_BITS+1)'(1);
  assign pos_wrap = (pos_inc >= {1'b0, cfg.delay_length});

  lfcf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk   (clk),
    .en    (cmd.capture || cmd.write_back),
    .we    (cmd.write_back),
    .addr  (pos_r),
    .wdata (wr_data),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      state_r   <= '0;
    end else if (cfg.clear) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (cmd.state_load) begin
        state_r <= sat_sample(upd_sum[ACC_BITS-1:COEF_BITS]);
      end
      if (cmd.write_back) begin
        if (pos_wrap) begin
          pos_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          pos_r <= pos_inc[ADDR_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= sample_in;
    end
    if (cmd.mul_load) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_load && (cmd.mul_sel == MUL_DRY)) begin
      delayed_r <= delayed;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.write_back) begin
      out_r <= delayed_r;
    end
  end

  assign sample_out = out_r;

endmodule

>>> rtl/lowpass_feedback_comb_filter_core.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter core
// Comb filter with a one-pole lowpass in its feedback path, Q1.23 samples.
// ----------------------------------------------------------------------------
// Each sample goes through these steps from acceptance to result: a read of
// the delay line, then three passes through a single shared multiplier
// (dry weight, damp weight, feedback gain) with a rounding step before the
// feedback pass, and a final step, held while the output register holds an
// untaken result, that writes the line and loads the output register. A new
// sample is taken in the cycle after its predecessor's result is registered,
// so samples never overlap. The delay line needs no clearing pass: after reset
// or a write of the delay length, entries read as zero until the position first wraps.
// Registers sit at byte addresses 0 (damp), 4 (feedback) and 8 (delay length),
// and should be written only while no sample is in flight.
module lowpass_feedback_comb_filter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  lfcf_in_if.sink                            in_chan,
  lfcf_out_if.source                         out_chan,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lfcf_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [lfcf_pkg::DATA_BITS-1:0]     cfg_pwdata,
  output logic [lfcf_pkg::DATA_BITS-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import lfcf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  lfcf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lfcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  lfcf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .sample_in  (in_chan.sample_in),
    .sample_out (out_chan.sample_out)
  );

endmodule

>>> rtl/lfcf_checker.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter checker
// Port-level assertions on sequencing and the result beat, bound to the core.
// ----------------------------------------------------------------------------
module lfcf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [lfcf_pkg::SAMPLE_BITS-1:0]   out_sample
);
  import lfcf_pkg::*;

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result beat changed while stalled");

  // One sample is worked on at a time through the whole multiplier sequence.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##5 !in_ready)
    else $error("input taken while a sample was still in flight");

  // A fresh result only appears at the end of a sample's work.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in flight");

  // Leaving reset the core is empty and ready.
  a_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("core not empty after reset");

endmodule

bind lowpass_feedback_comb_filter_core lfcf_checker u_lfcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sample (out_chan.sample_out)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter testbench
// Drives sample beats and register writes with random gaps on both channels.
// A bit-exact predictor of the delay line and lowpass state supplies the
// expected delayed sample for every accepted input beat.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfcf_pkg::*;

  localparam longint   Q_ONE     = longint'(1) << COEF_BITS;
  localparam longint   Q_HALF    = longint'(1) << (COEF_BITS - 1);
  localparam longint   S_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint   S_MIN     = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Predicts the delayed sample returned for each input beat.
  class comb_tap_board;
    logic signed [SAMPLE_BITS-1:0] line_mem [DELAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] lp_state;
    int unsigned                   wr_pos;
    int unsigned                   damp_w;
    int unsigned                   fb_gain;
    int unsigned                   line_len;
    logic signed [SAMPLE_BITS-1:0] taps_due [$];
    int                            errors;

    function new();
      errors   = 0;
      damp_w   = 0;
      fb_gain  = 0;
      line_len = LEN_RESET;
      clear_line();
    endfunction

    function void clear_line();
      foreach (line_mem[i]) line_mem[i] = '0;
      lp_state = '0;
      wr_pos   = 0;
    endfunction

    function logic signed [SAMPLE_BITS-1:0] sat24(input longint v);
      if (v > S_MAX) return S_MAX[SAMPLE_BITS-1:0];
      if (v < S_MIN) return S_MIN[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1:0];
    endfunction

    // Round to nearest with the half added before an arithmetic shift.
    function longint round_q(input longint v);
      return (v + Q_HALF) >>> COEF_BITS;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
      case (idx)
        REG_DAMP: begin
          damp_w = (value > Q_ONE) ? 32'(Q_ONE) : value;
        end
        REG_FEEDBACK: begin
          fb_gain = (value > Q_ONE - 1) ? 32'(Q_ONE - 1) : value;
        end
        REG_DELAY_LENGTH: begin
          if (value < 1) line_len = 1;
          else if (value > DELAY_DEPTH) line_len = DELAY_DEPTH;
          else line_len = value;
          clear_line();
        end
        default: begin
        end
      endcase
    endfunction

    function void take_sample(input logic signed [SAMPLE_BITS-1:0] x);
      logic signed [SAMPLE_BITS-1:0] delayed;
      longint                        acc;
      longint                        fb_term;
      int unsigned                   p;
      p = (wr_pos >= line_len) ? 0 : wr_pos;
      delayed = line_mem[p];
      acc = longint'(delayed) * (Q_ONE - longint'(damp_w)) +
            longint'(lp_state) * longint'(damp_w);
      lp_state = sat24(round_q(acc));
      fb_term = round_q(longint'(lp_state) * longint'(fb_gain));
      line_mem[p] = sat24(longint'(x) + fb_term);
      p++;
      if (p >= line_len) p = 0;
      wr_pos = p;
      taps_due.push_back(delayed);
    endfunction

    function void match_tap(input logic signed [SAMPLE_BITS-1:0] got);
      logic signed [SAMPLE_BITS-1:0] want;
      if (taps_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = taps_due.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [DATA_BITS-1:0]     cfg_pwdata;
  logic [DATA_BITS-1:0]     cfg_prdata;
  logic                     cfg_pready;

  lfcf_in_if  in_ch ();
  lfcf_out_if out_ch ();

  lowpass_feedback_comb_filter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  comb_tap_board board;
  bit            offering;
  bit            calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none during a calm phase.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom;
    if (r < 10) return S_MAX[SAMPLE_BITS-1:0];
    if (r < 20) return S_MIN[SAMPLE_BITS-1:0];
    if (r < 30) return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
    return raw[SAMPLE_BITS-1:0];
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    offering = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.take_sample(s);
  endtask

  // Registers are only touched once the line has delivered every result.
  task automatic settle();
    drop_valid();
    while (board.taps_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Result side: random stalls, every accepted beat checked in order.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        board.match_tap(out_ch.sample_out);
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  initial begin
    int          n;
    int          r;
    logic [31:0] len_val;
    board = new();
    calm  = 1'b0;
    offering = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A single-entry line feeds each beat straight back, so full-scale
    // inputs with the largest gain drive the write-back into saturation.
    cfg_write(REG_DAMP, 32'd0);
    cfg_write(REG_FEEDBACK, 32'd65535);
    cfg_write(REG_DELAY_LENGTH, 32'd1);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_sample(24'shFFFFFF);
    send_sample(24'sh000001);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);

    // Damp beyond unity clamps to one; a zero length behaves as one.
    cfg_write(REG_DAMP, 32'd131071);
    cfg_write(REG_FEEDBACK, 32'd32768);
    cfg_write(REG_DELAY_LENGTH, 32'd0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh003039);
    send_sample(24'shFFFFFF);

    // The spare address is ignored; rewriting the same length still clears.
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    cfg_write(REG_DAMP, 32'd65535);
    cfg_write(REG_FEEDBACK, 32'd65535);
    cfg_write(REG_DELAY_LENGTH, 32'd3);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh123456);
    cfg_write(REG_DELAY_LENGTH, 32'd3);
    send_sample(24'shFEDCBA);
    send_sample(24'sh000000);
    send_sample(24'sh000000);
    send_sample(24'sh000000);

    // Lengths above the line depth clamp to the full depth.
    cfg_write(REG_DELAY_LENGTH, 32'd4095);
    send_sample(24'sh400000);
    send_sample(24'shC00000);

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph % 4 == 1);
      r = $urandom_range(0, 9);
      if (r == 0) cfg_write(REG_DAMP, 32'd0);
      else if (r == 1) cfg_write(REG_DAMP, 32'd65536);
      else if (r == 2) cfg_write(REG_DAMP, $urandom_range(65537, 131071));
      else cfg_write(REG_DAMP, $urandom_range(0, 65536));
      r = $urandom_range(0, 9);
      if (r == 0) cfg_write(REG_FEEDBACK, 32'd0);
      else if (r == 1) cfg_write(REG_FEEDBACK, 32'd65535);
      else if (r < 6) cfg_write(REG_FEEDBACK, $urandom_range(40000, 65535));
      else cfg_write(REG_FEEDBACK, $urandom_range(0, 65535));
      // Mostly short lines so that the position wraps many times per phase.
      r = $urandom_range(0, 10);
      if (r == 0) len_val = 0;
      else if (r == 1) len_val = $urandom_range(2048, 4095);
      else if (r == 2) len_val = board.line_len;
      else if (r < 7) len_val = $urandom_range(1, 8);
      else len_val = $urandom_range(9, 64);
      if (r != 10) cfg_write(REG_DELAY_LENGTH, len_val);
      n = $urandom_range(45, 70);
      for (int k = 0; k < n; k++) begin
        if (ph == 2 && k == n / 2) begin
          drop_valid();
          while (board.taps_due.size() != 0) @(posedge clk);
        end
        send_sample(pick_sample());
      end
    end

    drop_valid();
    while (board.taps_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
